@@ sv/complex_2x2_eigenvalues_defines.svh @@
// Assertion macros for the complex 2x2 eigenvalue block.
// Used by complex_2x2_eigenvalues.sv; relies on clk and rst in the module scope.
`ifndef COMPLEX_2X2_EIGENVALUES_DEFINES_SVH
`define COMPLEX_2X2_EIGENVALUES_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset
`define C2E_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset
`define C2E_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
// Implication checked on every edge, reset included
`define C2E_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);
`else
`define C2E_ASSERT_NOW(lbl, ante, cons, msg)
`define C2E_ASSERT_NEXT(lbl, ante, cons, msg)
`define C2E_ASSERT_ALWAYS(lbl, ante, cons, msg)
`endif
`endif

@@ sv/c2eig_pkg.sv @@
// Types, constants and fixed-width helpers for the complex 2x2 eigenvalue block.
// Standalone; used by complex_2x2_eigenvalues.
package c2eig_pkg;

  localparam int DW = 32;

  // matrix_order codes
  localparam logic [1:0] ORDER_PASS  = 2'd1;
  localparam logic [1:0] ORDER_RESET = 2'd2;

  // Values that ride along with an item through the pipeline
  typedef struct packed {
    logic               pass;
    logic               zden;
    logic signed [31:0] m00_re;
    logic signed [31:0] m00_im;
    logic signed [31:0] tr;
    logic signed [31:0] ti;
    logic signed [31:0] dr;
    logic signed [31:0] di;
    logic signed [31:0] xr;
    logic signed [31:0] xi;
    logic signed [31:0] br;
    logic signed [31:0] bi;
  } ctx_t;

  // Digit-by-digit square root state (64-bit radicand, 32-bit root)
  typedef struct packed {
    logic [63:0] v;
    logic [34:0] rem;
    logic [31:0] root;
  } sq_t;

  // Restoring division state (32 quotient bits)
  typedef struct packed {
    logic        neg;
    logic        ovf;
    logic [63:0] rem;
    logic [63:0] den;
    logic [31:0] lo;
    logic [31:0] q;
  } dv_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] sat64(input logic signed [65:0] v);
    if (v > $signed({2'b00, 1'b0, {63{1'b1}}})) return {1'b0, {63{1'b1}}};
    if (v < $signed({2'b11, 1'b1, {63{1'b0}}})) return {1'b1, {63{1'b0}}};
    return v[63:0];
  endfunction

  // One root bit per call
  function automatic sq_t sq_step(input sq_t s);
    sq_t         o;
    logic [34:0] r2;
    logic [34:0] trial;
    r2    = {s.rem[32:0], s.v[63:62]};
    trial = {1'b0, s.root, 2'b01};
    o.v   = {s.v[61:0], 2'b00};
    if (r2 >= trial) begin
      o.rem  = r2 - trial;
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem  = r2;
      o.root = {s.root[30:0], 1'b0};
    end
    return o;
  endfunction

  // One quotient bit per call
  function automatic dv_t dv_step(input dv_t s);
    dv_t         o;
    logic [64:0] r2;
    logic [64:0] dd;
    o    = s;
    r2   = {s.rem, s.lo[31]};
    dd   = {1'b0, s.den};
    o.lo = {s.lo[30:0], 1'b0};
    if (r2 >= dd) begin
      o.rem = 64'(r2 - dd);
      o.q   = {s.q[30:0], 1'b1};
    end else begin
      o.rem = r2[63:0];
      o.q   = {s.q[30:0], 1'b0};
    end
    return o;
  endfunction

  // Saturate the magnitude and apply the sign
  function automatic logic signed [31:0] dv_result(input dv_t s);
    logic [31:0] limit;
    logic [31:0] qs;
    limit = s.neg ? 32'h80000000 : 32'h7FFFFFFF;
    qs    = (s.ovf || (s.q > limit)) ? limit : s.q;
    return s.neg ? $signed(-qs) : $signed(qs);
  endfunction

endpackage

@@ sv/complex_2x2_eigenvalues.sv @@
// Eigenvalues of a complex 2x2 matrix, fully pipelined.
// Depends on c2eig_pkg and complex_2x2_eigenvalues_defines.svh.
//
// Usage:
//  - s_axis carries one matrix per transfer (eight signed fixed-point parts).
//  - m_axis carries one result per transfer: eig_a = D / eig_b and
//    eig_b = (t +/- sqrt(t^2 - 4D)) / 2, with divide_fault in tuser.
//  - cfg_we/cfg_wdata write matrix_order; 1 passes m00 through as eig_a.
//    Write it only while no matrix is in flight.
//  - From input transfer to output valid the pipeline has five stages
//    for t, D, d and |d|^2, two 33-stage square roots (radicand load plus
//    32 root bits) for |d| and for s, one stage for eig_b, two for the
//    division products and sums, a 33-stage restoring divider (setup plus
//    32 quotient bits) and the output register.
//  - Throughput is one matrix per cycle while the output is not stalled.
//  - All stages advance together; when the output holds an untaken result,
//    the whole pipeline stalls and s_axis_tready drops, losing nothing.
//  - Reset clears all valid bits and sets matrix_order to 2.
`include "complex_2x2_eigenvalues_defines.svh"

module complex_2x2_eigenvalues #(
  parameter int FRAC_BITS = 28
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_wdata,      // matrix_order
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // m00_re, m00_im, m01_re, m01_im, m10_re, m10_im, m11_re, m11_im
  input  logic [255:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // eig_a_re, eig_a_im, eig_b_re, eig_b_im
  output logic [127:0] m_axis_tdata,
  output logic [0:0]   m_axis_tuser    // divide_fault
);
  import c2eig_pkg::*;

  localparam int IX_SQM0 = 5;
  localparam int IX_SQS0 = IX_SQM0 + DW + 1;
  localparam int IX_B    = IX_SQS0 + DW + 1;
  localparam int IX_MUL  = IX_B + 1;
  localparam int IX_SUM  = IX_B + 2;
  localparam int IX_DV0  = IX_B + 3;
  localparam int IX_OUT  = IX_DV0 + DW + 1;
  localparam int LAT     = IX_OUT + 1;

  // Round half up by FRAC_BITS, then saturate to 32 bits
  function automatic logic signed [31:0] rnd(input logic signed [63:0] v);
    logic signed [65:0] t;
    t = 66'(v) + (66'sd1 <<< (FRAC_BITS - 1));
    t = t >>> FRAC_BITS;
    return sat32(t);
  endfunction

  // Magnitude, overflow check and first remainder for num * 2^F / den
  function automatic dv_t dv_init(input logic signed [63:0] num, input logic [63:0] den);
    dv_t         o;
    logic [63:0] mag;
    logic [63:0] hi;
    mag   = num[63] ? 64'(-num) : 64'(num);
    hi    = mag >> (DW - FRAC_BITS);
    o.neg = num[63];
    o.ovf = (hi >= den);
    o.rem = hi;
    o.den = den;
    o.lo  = 32'(mag << FRAC_BITS);
    o.q   = '0;
    return o;
  endfunction

  logic [1:0] matrix_order;
  logic       en;
  logic       vld [0:LAT-1];
  ctx_t       cx    [0:IX_OUT-1];
  ctx_t       cx_in [0:IX_OUT-1];
  ctx_t       ctx0;

  logic signed [63:0] pm [0:7];
  logic signed [31:0] p2r, p2i, q2r, q2i;
  logic signed [63:0] tm [0:3];
  logic signed [31:0] tpr, tpi;
  logic signed [63:0] xx0, xx1;
  logic signed [63:0] nm [0:5];
  logic signed [63:0] na, nb;
  logic [63:0]        den;

  sq_t sqm   [0:DW];
  sq_t sqs_r [0:DW];
  sq_t sqs_i [0:DW];
  dv_t dva   [0:DW];
  dv_t dvb   [0:DW];

  logic signed [31:0] o_ar, o_ai, o_br, o_bi;
  logic               o_fault;
  logic               o_pass;

  logic signed [31:0] i00r, i00i, i01r, i01i, i10r, i10i, i11r, i11i;
  logic [33:0]        sa, sb;
  logic [31:0]        sr_m, si_m;
  logic signed [31:0] sr, si;
  logic signed [32:0] ur, ui;
  logic [63:0]        den_c;

  // Input unpack
  assign i00r = s_axis_tdata[31:0];
  assign i00i = s_axis_tdata[63:32];
  assign i01r = s_axis_tdata[95:64];
  assign i01i = s_axis_tdata[127:96];
  assign i10r = s_axis_tdata[159:128];
  assign i10i = s_axis_tdata[191:160];
  assign i11r = s_axis_tdata[223:192];
  assign i11i = s_axis_tdata[255:224];

  // Global advance: the output register is free or being taken
  assign en            = !vld[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[LAT-1];
  assign m_axis_tdata  = {o_bi, o_br, o_ai, o_ar};
  assign m_axis_tuser  = o_fault;

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_order <= ORDER_RESET;
    end else if (cfg_we) begin
      matrix_order <= cfg_wdata;
    end
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= s_axis_tvalid;
      for (int i = 1; i < LAT; i++) vld[i] <= vld[i-1];
    end
  end

  // Context entering the pipe
  always_comb begin
    ctx0        = '{default: '0};
    ctx0.pass   = (matrix_order == ORDER_PASS);
    ctx0.m00_re = i00r;
    ctx0.m00_im = i00i;
    ctx0.tr     = sat32(66'(i00r) + 66'(i11r));
    ctx0.ti     = sat32(66'(i00i) + 66'(i11i));
  end

  // Context updates where a stage produces a carried value
  always_comb begin
    for (int i = 0; i < IX_OUT; i++) cx_in[i] = cx[i];
    cx_in[1].dr = sat32(66'(p2r) - 66'(q2r));
    cx_in[1].di = sat32(66'(p2i) - 66'(q2i));
    cx_in[2].xr = sat32(66'(tpr) - 66'(sat32(66'(cx[2].dr) <<< 2)));
    cx_in[2].xi = sat32(66'(tpi) - 66'(sat32(66'(cx[2].di) <<< 2)));
    cx_in[IX_B-1].br = ur[32:1];
    cx_in[IX_B-1].bi = ui[32:1];
    cx_in[IX_MUL].zden = (den_c == 64'd0);
  end

  // Square root arguments from m = isqrt(|d|^2)
  assign sa = 34'(sqm[DW].root) + 34'(cx[IX_SQM0+DW].xr);
  assign sb = 34'(sqm[DW].root) - 34'(cx[IX_SQM0+DW].xr);

  // eig_b from t and the saturated root
  always_comb begin
    sr_m = sqs_r[DW].root[31] ? 32'h7FFFFFFF : sqs_r[DW].root;
    si_m = sqs_i[DW].root[31] ? 32'h7FFFFFFF : sqs_i[DW].root;
    sr   = $signed(sr_m);
    si   = cx[IX_B-1].xi[31] ? -$signed(si_m) : $signed(si_m);
    if (!cx[IX_B-1].tr[31]) begin
      ur = 33'(cx[IX_B-1].tr) + 33'(sr);
      ui = 33'(cx[IX_B-1].ti) + 33'(si);
    end else begin
      ur = 33'(cx[IX_B-1].tr) - 33'(sr);
      ui = 33'(cx[IX_B-1].ti) - 33'(si);
    end
  end

  assign den_c = 64'(nm[4]) + 64'(nm[5]);

  // Datapath registers
  always_ff @(posedge clk) begin
    if (en) begin
      cx[0] <= ctx0;
      for (int i = 1; i < IX_OUT; i++) cx[i] <= cx_in[i-1];

      // products of m00*m11 and m01*m10
      pm[0] <= 64'(i00r) * 64'(i11r);
      pm[1] <= 64'(i00i) * 64'(i11i);
      pm[2] <= 64'(i00r) * 64'(i11i);
      pm[3] <= 64'(i00i) * 64'(i11r);
      pm[4] <= 64'(i01r) * 64'(i10r);
      pm[5] <= 64'(i01i) * 64'(i10i);
      pm[6] <= 64'(i01r) * 64'(i10i);
      pm[7] <= 64'(i01i) * 64'(i10r);

      // finish the determinant products; start t*t
      p2r <= rnd(sat64(66'(pm[0]) - 66'(pm[1])));
      p2i <= rnd(sat64(66'(pm[2]) + 66'(pm[3])));
      q2r <= rnd(sat64(66'(pm[4]) - 66'(pm[5])));
      q2i <= rnd(sat64(66'(pm[6]) + 66'(pm[7])));
      tm[0] <= 64'(cx[0].tr) * 64'(cx[0].tr);
      tm[1] <= 64'(cx[0].ti) * 64'(cx[0].ti);
      tm[2] <= 64'(cx[0].tr) * 64'(cx[0].ti);
      tm[3] <= 64'(cx[0].ti) * 64'(cx[0].tr);

      // finish t*t
      tpr <= rnd(sat64(66'(tm[0]) - 66'(tm[1])));
      tpi <= rnd(sat64(66'(tm[2]) + 66'(tm[3])));

      // |d|^2
      xx0 <= 64'(cx[3].xr) * 64'(cx[3].xr);
      xx1 <= 64'(cx[3].xi) * 64'(cx[3].xi);
      sqm[0] <= '{v: 64'(xx0) + 64'(xx1), rem: '0, root: '0};
      for (int k = 1; k <= DW; k++) sqm[k] <= sq_step(sqm[k-1]);

      // root of (m +/- re d) * 2^(F-1)
      sqs_r[0] <= '{v: 64'(sa) << (FRAC_BITS - 1), rem: '0, root: '0};
      sqs_i[0] <= '{v: 64'(sb) << (FRAC_BITS - 1), rem: '0, root: '0};
      for (int k = 1; k <= DW; k++) begin
        sqs_r[k] <= sq_step(sqs_r[k-1]);
        sqs_i[k] <= sq_step(sqs_i[k-1]);
      end

      // D * conj(b) and |b|^2
      nm[0] <= 64'(cx[IX_B].dr) * 64'(cx[IX_B].br);
      nm[1] <= 64'(cx[IX_B].di) * 64'(cx[IX_B].bi);
      nm[2] <= 64'(cx[IX_B].di) * 64'(cx[IX_B].br);
      nm[3] <= 64'(cx[IX_B].dr) * 64'(cx[IX_B].bi);
      nm[4] <= 64'(cx[IX_B].br) * 64'(cx[IX_B].br);
      nm[5] <= 64'(cx[IX_B].bi) * 64'(cx[IX_B].bi);
      na    <= sat64(66'(nm[0]) + 66'(nm[1]));
      nb    <= sat64(66'(nm[2]) - 66'(nm[3]));
      den   <= den_c;

      // divider
      dva[0] <= dv_init(na, den);
      dvb[0] <= dv_init(nb, den);
      for (int k = 1; k <= DW; k++) begin
        dva[k] <= dv_step(dva[k-1]);
        dvb[k] <= dv_step(dvb[k-1]);
      end

      // output register
      o_pass <= cx[IX_OUT-1].pass;
      if (cx[IX_OUT-1].pass) begin
        o_ar    <= cx[IX_OUT-1].m00_re;
        o_ai    <= cx[IX_OUT-1].m00_im;
        o_br    <= '0;
        o_bi    <= '0;
        o_fault <= 1'b0;
      end else if (cx[IX_OUT-1].zden) begin
        o_ar    <= '0;
        o_ai    <= '0;
        o_br    <= cx[IX_OUT-1].br;
        o_bi    <= cx[IX_OUT-1].bi;
        o_fault <= 1'b1;
      end else begin
        o_ar    <= dv_result(dva[DW]);
        o_ai    <= dv_result(dvb[DW]);
        o_br    <= cx[IX_OUT-1].br;
        o_bi    <= cx[IX_OUT-1].bi;
        o_fault <= 1'b0;
      end
    end
  end

  // Checks
  `C2E_ASSERT_NOW(a_fault_zero_a, m_axis_tvalid && m_axis_tuser[0],
                  m_axis_tdata[63:0] == 64'd0 && m_axis_tdata[127:64] == 64'd0,
                  "divide fault with nonzero eigenvalue")
  `C2E_ASSERT_NOW(a_fault_iff_zero_b, m_axis_tvalid && !o_pass,
                  m_axis_tuser[0] == (m_axis_tdata[127:64] == 64'd0),
                  "fault flag disagrees with zero eig_b")
  `C2E_ASSERT_NOW(a_pass_clean, m_axis_tvalid && o_pass,
                  !m_axis_tuser[0] && m_axis_tdata[127:64] == 64'd0,
                  "pass-through result carries eig_b or fault")
  `C2E_ASSERT_ALWAYS(a_reset_empty, $past(rst), !m_axis_tvalid,
                     "output valid right after reset")

endmodule
